/* hw/rtl/fiq_pkg.sv */
// fiq_pkg: types and constants for the float-to-int quantizer.
// Depends on nothing; imported by float_to_int_quantizer_top.
package fiq_pkg;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH = 2'd2;

   localparam logic WM_INT8 = 1'b0;
   localparam logic WM_INT4 = 1'b1;

   localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;

   localparam int unsigned EXP_W    = 10;  // unbiased operand exponent
   localparam int unsigned QEXP_W   = 11;  // quotient exponent
   localparam int unsigned MANT_W   = 24;
   localparam int unsigned REM_W    = 26;
   localparam int unsigned QBITS    = 27;  // 24 mantissa + guard + 2 sticky
   localparam int unsigned STEPS    = 3;   // quotient bits per divider stage
   localparam int unsigned DIV_STGS = QBITS / STEPS;
   localparam int unsigned FRAC_W   = 29;  // fixed point LSB is 2^-29
   localparam int unsigned FIX_W    = 39;  // |q| < 2^10
   localparam int unsigned SUM_W    = 41;
   localparam int unsigned MAG_W    = 40;
   localparam int unsigned RMAG_W   = 12;
   localparam int unsigned NSTAGES  = DIV_STGS + 8;

   localparam logic [RMAG_W-1:0] POS8 = 12'd127;
   localparam logic [RMAG_W-1:0] NEG8 = 12'd128;
   localparam logic [RMAG_W-1:0] POS4 = 12'd7;
   localparam logic [RMAG_W-1:0] NEG4 = 12'd8;

   typedef struct packed {
      logic                    sign;
      logic                    is_zero;
      logic                    is_inf;
      logic                    is_nan;
      logic [MANT_W-1:0]       mant;
      logic signed [EXP_W-1:0] expo;
   } fp_type;

   typedef struct packed {
      logic sign;
      logic nan;
      logic sat;
      logic zero;
      logic eov;
   } meta_type;

   typedef struct packed {
      meta_type                 meta;
      logic [MANT_W-1:0]        mv;
      logic [MANT_W-1:0]        ms;
      logic signed [EXP_W-1:0]  ev;
      logic signed [EXP_W-1:0]  es;
   } dec_type;

   typedef struct packed {
      meta_type                 meta;
      logic [REM_W-1:0]         rem;
      logic [MANT_W-1:0]        dvs;
      logic [QBITS-1:0]         quo;
      logic signed [QEXP_W-1:0] eq;
   } div_type;

   typedef struct packed {
      meta_type                 meta;
      logic [MANT_W-1:0]        mant;
      logic signed [QEXP_W-1:0] eq;
   } rnd_type;

   function automatic fp_type unpack_fp(input logic [31:0] f);
      fp_type     r;
      logic [7:0] e;
      logic [22:0] m;
      logic [4:0] lz;
      logic       found;
      e = f[30:23];
      m = f[22:0];
      lz = '0;
      found = 1'b0;
      for (int i = 22; i >= 0; i--) begin
         if (!found && m[i]) begin
            lz = 5'(22 - i);
            found = 1'b1;
         end
      end
      r.sign    = f[31];
      r.is_zero = (e == 8'd0) && (m == 23'd0);
      r.is_inf  = (e == 8'hFF) && (m == 23'd0);
      r.is_nan  = (e == 8'hFF) && (m != 23'd0);
      if (e == 8'd0) begin
         r.mant = MANT_W'({1'b0, m}) << (lz + 5'd1);
         r.expo = -10'sd127 - $signed({5'd0, lz});
      end else begin
         r.mant = {1'b1, m};
         r.expo = $signed({2'b00, e}) - 10'sd127;
      end
      return r;
   endfunction

endpackage

/* hw/rtl/float_to_int_quantizer_top.sv */
// float_to_int_quantizer_top: float32 / scale + zero point, rounded and clamped to int8/int4.
// One word per cycle sustained while rsp is not stalled.
// Stages: decode, prescale, 9 divider stages (3 quotient bits each), 6 round/add/clamp stages.
// The whole pipeline holds when rsp is stalled.
// Synchronous active-high reset clears valid bits and config (scale 1.0, zero 0, int8).
// Depends on fiq_pkg.
module float_to_int_quantizer_top import fiq_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [31:0]            req_tdata,   // [31:0] sample_bits
   input  logic                   req_tlast,   // end_of_vector
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,   // [7:0] quantized
   output logic                   rsp_tlast,   // end_of_vector_out
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_data
);

   logic [31:0]        scale_ff;
   logic signed [7:0]  zoff_ff;
   logic               wmode_ff;
   logic [NSTAGES-1:0] v_ff;
   logic               en;

   dec_type dec_ff, dec_in;
   div_type dv_ff [DIV_STGS+1];
   div_type dv_in [DIV_STGS+1];
   rnd_type rnd_ff, rnd_in;
   meta_type fix_meta_ff, fix_meta_in;
   logic [FIX_W-1:0] fix_ff, fix_in;
   meta_type sum_meta_ff;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   meta_type abs_meta_ff;
   logic [MAG_W-1:0] mag_ff, mag_in;
   logic abs_neg_ff, abs_neg_in;
   meta_type enc_meta_ff;
   logic [RMAG_W-1:0] rmag_ff, rmag_in;
   logic enc_neg_ff;
   logic [7:0] q_ff, q_in;
   logic eov_ff;

   assign en         = ~v_ff[NSTAGES-1] | rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = v_ff[NSTAGES-1];
   assign rsp_tdata  = q_ff;
   assign rsp_tlast  = eov_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
         zoff_ff  <= '0;
         wmode_ff <= WM_INT8;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SCALE: scale_ff <= csr_data;
            CSR_ZERO:  zoff_ff  <= $signed(csr_data[7:0]);
            CSR_WIDTH: wmode_ff <= csr_data[0];
            default:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NSTAGES-2:0], req_tvalid};
      end
   end

   // decode and normalize
   always_comb begin
      fp_type v;
      fp_type s;
      v = unpack_fp(req_tdata);
      s = unpack_fp(scale_ff);
      if (s.is_zero) begin
         s.sign = 1'b0;
         s.mant = {1'b1, 23'd0};
         s.expo = '0;
      end
      dec_in.meta.sign = v.sign ^ s.sign;
      dec_in.meta.nan  = v.is_nan | s.is_nan | (v.is_inf & s.is_inf);
      dec_in.meta.sat  = v.is_inf;
      dec_in.meta.zero = v.is_zero | s.is_inf;
      dec_in.meta.eov  = req_tlast;
      dec_in.mv = v.mant;
      dec_in.ms = s.mant;
      dec_in.ev = v.expo;
      dec_in.es = s.expo;
   end

   // prescale so the quotient lies in [1,2)
   always_comb begin
      logic lt;
      lt = dec_ff.mv < dec_ff.ms;
      dv_in[0].meta = dec_ff.meta;
      dv_in[0].dvs  = dec_ff.ms;
      dv_in[0].quo  = '0;
      dv_in[0].rem  = lt ? {1'b0, dec_ff.mv, 1'b0} : {2'b00, dec_ff.mv};
      dv_in[0].eq   = QEXP_W'(dec_ff.ev) - QEXP_W'(dec_ff.es) - QEXP_W'({1'b0, lt});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dec_ff   <= dec_in;
         dv_ff[0] <= dv_in[0];
      end
   end

   for (genvar k = 0; k < DIV_STGS; k++) begin : g_div
      always_comb begin
         div_type d;
         d = dv_ff[k];
         for (int j = 0; j < STEPS; j++) begin
            if (d.rem >= {2'b00, d.dvs}) begin
               d.rem = d.rem - {2'b00, d.dvs};
               d.quo = {d.quo[QBITS-2:0], 1'b1};
            end else begin
               d.quo = {d.quo[QBITS-2:0], 1'b0};
            end
            d.rem = {d.rem[REM_W-2:0], 1'b0};
         end
         dv_in[k+1] = d;
      end
      always_ff @(posedge clock) begin
         if (en) begin
            dv_ff[k+1] <= dv_in[k+1];
         end
      end
   end

   // round quotient to nearest even
   always_comb begin
      div_type d;
      logic [MANT_W:0] m;
      logic g, st, up;
      d  = dv_ff[DIV_STGS];
      g  = d.quo[2];
      st = (|d.quo[1:0]) | (|d.rem);
      up = g & (st | d.quo[3]);
      m  = {1'b0, d.quo[QBITS-1:3]} + (MANT_W+1)'(up);
      rnd_in.meta = d.meta;
      if (m[MANT_W]) begin
         rnd_in.mant = {1'b1, 23'd0};
         rnd_in.eq   = d.eq + 11'sd1;
      end else begin
         rnd_in.mant = m[MANT_W-1:0];
         rnd_in.eq   = d.eq;
      end
   end

   // align |q| to fixed point
   always_comb begin
      logic [62:0] wide;
      logic [5:0]  shamt;
      shamt  = 6'(rnd_ff.eq + 11'sd30);
      wide   = 63'(rnd_ff.mant) << shamt;
      fix_in = wide[62:24];
      fix_in[0] = wide[24] | (|wide[23:0]);
      if (rnd_ff.meta.zero) begin
         fix_in = '0;
      end else if (rnd_ff.eq < -11'sd30) begin
         fix_in = FIX_W'(1);
      end
      fix_meta_in     = rnd_ff.meta;
      fix_meta_in.sat = rnd_ff.meta.sat | (~rnd_ff.meta.zero & (rnd_ff.eq > 11'sd9));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rnd_ff      <= rnd_in;
         fix_meta_ff <= fix_meta_in;
         fix_ff      <= fix_in;
      end
   end

   always_comb begin
      logic signed [SUM_W-1:0] sq;
      sq = $signed({2'b00, fix_ff});
      if (fix_meta_ff.sign) begin
         sq = -sq;
      end
      sum_in = sq + $signed({{4{zoff_ff[7]}}, zoff_ff, 29'd0});
   end

   always_comb begin
      logic signed [SUM_W-1:0] t;
      abs_neg_in = sum_ff[SUM_W-1];
      t = abs_neg_in ? -sum_ff : sum_ff;
      mag_in = t[MAG_W-1:0];
   end

   // emulate the float rounding of the sum at the half-integer thresholds
   always_comb begin
      logic [5:0]  idx;
      logic        found;
      logic [SUM_W-1:0] a;
      idx   = '0;
      found = 1'b0;
      for (int i = MAG_W - 1; i >= 27; i--) begin
         if (!found && mag_ff[i]) begin
            idx   = 6'(i);
            found = 1'b1;
         end
      end
      a = {1'b0, mag_ff} + (SUM_W'(1) << 28) + (SUM_W'(1) << (idx - 6'd24));
      rmag_in = found ? a[SUM_W-1:FRAC_W] : '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_meta_ff <= fix_meta_ff;
         sum_ff      <= sum_in;
         abs_meta_ff <= sum_meta_ff;
         mag_ff      <= mag_in;
         abs_neg_ff  <= abs_neg_in;
         enc_meta_ff <= abs_meta_ff;
         rmag_ff     <= rmag_in;
         enc_neg_ff  <= abs_neg_ff;
      end
   end

   always_comb begin
      logic [RMAG_W-1:0] pos_lim, neg_lim;
      logic [RMAG_W-1:0] neg_val;
      pos_lim = (wmode_ff == WM_INT4) ? POS4 : POS8;
      neg_lim = (wmode_ff == WM_INT4) ? NEG4 : NEG8;
      neg_val = -rmag_ff;
      if (enc_meta_ff.nan) begin
         q_in = '0;
      end else if (enc_meta_ff.sat) begin
         q_in = enc_meta_ff.sign ? 8'(-neg_lim) : pos_lim[7:0];
      end else if (enc_neg_ff) begin
         q_in = (rmag_ff > neg_lim) ? 8'(-neg_lim) : neg_val[7:0];
      end else begin
         q_in = (rmag_ff > pos_lim) ? pos_lim[7:0] : rmag_ff[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff   <= q_in;
         eov_ff <= enc_meta_ff.eov;
      end
   end

endmodule
